// File: design/mpm_pkg.sv
// Package for the modular power block: shared types and constants.
// No dependencies; used by all modules under design/.
package mpm_pkg;

    // Residue width and modulus p = 1000000007
    localparam int unsigned RES_W = 30;
    localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;

    // Barrett constant floor(2^60 / p), 31 bits
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;

    // Reduction bounds on the 32-bit remainder estimate
    localparam logic [31:0] MOD_X1 = 32'd1000000007;
    localparam logic [31:0] MOD_X2 = 32'd2000000014;

    // Pipeline depth of the modular multiplier
    localparam int unsigned MM_STAGES = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // new transaction: acc=1, base=2, exp=inner
        logic prep;         // second run: base=acc-1 (wrapped), acc=1, exp=outer
        logic mm_start;     // issue one modular multiply
        logic mm_sel_base;  // second operand: 1 = base, 0 = acc (square)
        logic acc_wr;       // write multiplier result into acc
        logic exp_shift;    // move to next exponent bit
    } mpm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic exp_msb;      // current exponent bit
        logic mm_done;      // multiplier result valid this cycle
    } mpm_stat_t;

endpackage

// File: design/mpm_modmul.sv
// Pipelined modular multiplier a*b mod p using Barrett reduction.
// Depends on mpm_pkg.
module mpm_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mpm_pkg::RES_W-1:0] a,
    input  logic [mpm_pkg::RES_W-1:0] b,
    output logic                      done,
    output logic [mpm_pkg::RES_W-1:0] res
);

    logic [mpm_pkg::MM_STAGES-1:0] vld_reg, vld_next;

    logic [59:0]               prod_reg, prod_next;
    logic [61:0]               t_reg, t_next;
    logic [31:0]               lo2_reg, lo2_next;
    logic [31:0]               qp_reg, qp_next;
    logic [31:0]               lo3_reg, lo3_next;
    logic [31:0]               r_reg, r_next;
    logic [mpm_pkg::RES_W-1:0] res_reg, res_next;
    logic [60:0]               qp_full;

    // Stage 1: full product, below p^2 < 2^60
    assign prod_next = 60'(a) * 60'(b);

    // Stage 2: quotient estimate numerator, (x >> 29) * mu
    assign t_next   = 62'(prod_reg[59:29]) * 62'(mpm_pkg::BARRETT_MU);
    assign lo2_next = prod_reg[31:0];

    // Stage 3: q * p, only the low 32 bits matter since x - q*p < 3p
    assign qp_full  = 61'(t_reg[61:31]) * 61'(mpm_pkg::MODULUS);
    assign qp_next  = qp_full[31:0];
    assign lo3_next = lo2_reg;

    // Stage 4: remainder estimate
    assign r_next = lo3_reg - qp_reg;

    // Stage 5: at most two subtractions of p
    always_comb
    begin
        if (r_reg >= mpm_pkg::MOD_X2)
        begin
            res_next = mpm_pkg::RES_W'(r_reg - mpm_pkg::MOD_X2);
        end
        else if (r_reg >= mpm_pkg::MOD_X1)
        begin
            res_next = mpm_pkg::RES_W'(r_reg - mpm_pkg::MOD_X1);
        end
        else
        begin
            res_next = r_reg[mpm_pkg::RES_W-1:0];
        end
    end

    // Valid tag travels with the operation
    assign vld_next = {vld_reg[mpm_pkg::MM_STAGES-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload pipeline, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        t_reg    <= t_next;
        lo2_reg  <= lo2_next;
        qp_reg   <= qp_next;
        lo3_reg  <= lo3_next;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign done = vld_reg[mpm_pkg::MM_STAGES-1];
    assign res  = res_reg;

    // Controller never overlaps operations
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_reg))
        else $error("modmul: more than one operation in flight");

    // Reduced result is a proper residue
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_reg < mpm_pkg::MODULUS))
        else $error("modmul: result not below modulus");

endmodule

// File: design/mpm_datapath.sv
// Datapath: accumulator, base, exponent shift registers and the multiplier.
// Depends on mpm_pkg and mpm_modmul.
module mpm_datapath #(
    parameter int unsigned EXP_BITS = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [30:0]               outer_exponent,
    input  logic [30:0]               inner_exponent,
    input  mpm_pkg::mpm_cmd_t         cmd,
    output mpm_pkg::mpm_stat_t        stat,
    output logic [mpm_pkg::RES_W-1:0] residue
);

    logic [mpm_pkg::RES_W-1:0] acc_reg, acc_next;
    logic [mpm_pkg::RES_W-1:0] base_reg, base_next;
    logic [EXP_BITS-1:0]       exp_reg, exp_next;
    logic [EXP_BITS-1:0]       outer_reg, outer_next;

    logic [EXP_BITS+30:0]      inner_ext, outer_ext;
    logic [mpm_pkg::RES_W-1:0] mm_b, mm_res;
    logic                      mm_done;

    // Exponents keep only their low EXP_BITS bits, zero-extended if wider
    assign inner_ext = {{EXP_BITS{1'b0}}, inner_exponent};
    assign outer_ext = {{EXP_BITS{1'b0}}, outer_exponent};

    assign mm_b = cmd.mm_sel_base ? base_reg : acc_reg;

    mpm_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mm_start),
        .a     (acc_reg),
        .b     (mm_b),
        .done  (mm_done),
        .res   (mm_res)
    );

    // Register updates under controller command
    always_comb
    begin
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        outer_next = outer_reg;
        if (cmd.load)
        begin
            acc_next   = mpm_pkg::RES_W'(1);
            base_next  = mpm_pkg::RES_W'(2);
            exp_next   = inner_ext[EXP_BITS-1:0];
            outer_next = outer_ext[EXP_BITS-1:0];
        end
        else if (cmd.prep)
        begin
            // base = 2^m - 1, wrapped into 0 .. p-1
            if (acc_reg == '0)
            begin
                base_next = mpm_pkg::MODULUS - mpm_pkg::RES_W'(1);
            end
            else
            begin
                base_next = acc_reg - mpm_pkg::RES_W'(1);
            end
            acc_next = mpm_pkg::RES_W'(1);
            exp_next = outer_reg;
        end
        else
        begin
            if (cmd.acc_wr)
            begin
                acc_next = mm_res;
            end
            if (cmd.exp_shift)
            begin
                exp_next = exp_reg << 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        outer_reg <= outer_next;
    end

    assign stat.exp_msb = exp_reg[EXP_BITS-1];
    assign stat.mm_done = mm_done;
    assign residue      = acc_reg;

endmodule

// File: design/mpm_ctrl.sv
// Controller: sequences two square-and-multiply runs over the exponent bits.
// Depends on mpm_pkg.
module mpm_ctrl #(
    parameter int unsigned EXP_BITS = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mpm_pkg::mpm_stat_t stat,
    output mpm_pkg::mpm_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    localparam int unsigned CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SQW  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MULW = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_PREP = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(EXP_BITS - 1);
                    phase_next = 1'b0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mm_start = 1'b1;
                state_next   = ST_SQW;
            end
            ST_SQW:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_wr = 1'b1;
                    state_next = stat.exp_msb ? ST_MUL : ST_STEP;
                end
            end
            ST_MUL:
            begin
                cmd.mm_start    = 1'b1;
                cmd.mm_sel_base = 1'b1;
                state_next      = ST_MULW;
            end
            ST_MULW:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_wr = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.exp_shift = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = phase_reg ? ST_DONE : ST_PREP;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_SQ;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = CNT_W'(EXP_BITS - 1);
                phase_next = 1'b1;
                state_next = ST_SQ;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    // Accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("ctrl: accepted transaction did not start");

    // Result strobe is a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("ctrl: done held more than one cycle");

    // Multiplier results arrive only while waiting for them
    a_mm_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mm_done |-> (state_reg == ST_SQW || state_reg == ST_MULW))
        else $error("ctrl: multiplier result outside a wait state");

endmodule

// File: design/mod_prime_power_of_mersenne_top.sv
// Computes (2^m - 1)^n mod 1000000007; top level joining controller and datapath.
// Every square and multiply goes through one shared pipelined modular multiplier.
// A new transaction is taken only in idle, once the previous one has finished.
// Reset clears the controller and multiplier valids; no result is pending after.
// Depends on mpm_pkg, mpm_ctrl, mpm_datapath, mpm_modmul.
module mod_prime_power_of_mersenne_top #(
    parameter int unsigned EXP_BITS = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [30:0]               outer_exponent,
    input  logic [30:0]               inner_exponent,
    output logic                      done,
    output logic [mpm_pkg::RES_W-1:0] residue
);

    mpm_pkg::mpm_cmd_t  cmd;
    mpm_pkg::mpm_stat_t stat;

    mpm_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mpm_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .outer_exponent (outer_exponent),
        .inner_exponent (inner_exponent),
        .cmd            (cmd),
        .stat           (stat),
        .residue        (residue)
    );

endmodule

// File: sim/mod_prime_power_of_mersenne_top_tb.sv
`timescale 1ns / 1ps
// Testbench for mod_prime_power_of_mersenne_top: directed rows, then random exponent pairs.
// Each residue is checked against a listed value or a local square-and-multiply predictor. Depends on mpm_pkg.
module mod_prime_power_of_mersenne_top_tb;

    localparam int unsigned     RES_W      = mpm_pkg::RES_W;
    localparam longint unsigned PRIME      = 64'd1000000007;
    localparam logic [30:0]     EXP_MAX    = 31'h7FFF_FFFF;
    localparam int unsigned     GAP_MAX    = 850;
    localparam int unsigned     DRAIN_WAIT = 850;
    localparam longint unsigned TIMEOUT_NS = 64'd80_000_000;

    typedef struct {
        logic [30:0]      outer;
        logic [30:0]      inner;
        logic             known;
        logic [RES_W-1:0] residue;
    } exp_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [30:0]      outer_exponent = '0;
    logic [30:0]      inner_exponent = '0;
    logic             busy;
    logic             done;
    logic [RES_W-1:0] residue;

    logic [RES_W-1:0] pending_residues[$];
    logic [RES_W-1:0] oldest_residue;
    exp_row_t         directed_rows[$];
    int               mismatches = 0;

    mod_prime_power_of_mersenne_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .outer_exponent (outer_exponent),
        .inner_exponent (inner_exponent),
        .done           (done),
        .residue        (residue)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // base^e mod p, walking all 31 exponent bits from the top
    function automatic longint unsigned power_mod_prime(longint unsigned base, logic [30:0] e);
        longint unsigned acc;
        longint unsigned b;
        acc = 1;
        b   = base % PRIME;
        for (int i = 30; i >= 0; i--)
        begin
            acc = (acc * acc) % PRIME;
            if (e[i])
                acc = (acc * b) % PRIME;
        end
        return acc;
    endfunction

    // (2^m - 1)^n mod p
    function automatic logic [RES_W-1:0] mersenne_power(logic [30:0] n, logic [30:0] m);
        longint unsigned base;
        base = (power_mod_prime(64'd2, m) + PRIME - 1) % PRIME;
        return RES_W'(power_mod_prime(base, n));
    endfunction

    // Mix of corner values and full-width random exponents
    function automatic logic [30:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'($urandom_range(1, 64));
            2:       return EXP_MAX;
            3:       return 31'd1 << $urandom_range(0, 30);
            4:       return EXP_MAX - 31'($urandom_range(0, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic void add_row(logic [30:0] n, logic [30:0] m, logic known,
                                    logic [RES_W-1:0] res);
        exp_row_t row;
        row.outer   = n;
        row.inner   = m;
        row.known   = known;
        row.residue = res;
        directed_rows.push_back(row);
    endfunction

    // Present one transaction, hold it until accepted, log the expected residue.
    // Entered and left just after a falling edge.
    task automatic send_exponents(logic [30:0] n, logic [30:0] m, logic known,
                                  logic [RES_W-1:0] res);
        start          <= 1'b1;
        outer_exponent <= n;
        inner_exponent <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (known)
            pending_residues.push_back(res);
        else
            pending_residues.push_back(mersenne_power(n, m));
        @(negedge clk);
    endtask

    // Random sender idle; long gaps land anywhere in the busy window
    task automatic sender_gap(int unsigned pct);
        int unsigned len;
        if ($urandom_range(0, 99) < pct)
        begin
            len = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, GAP_MAX);
            start <= 1'b0;
            repeat (len)
                @(negedge clk);
        end
    endtask

    // Hold off until every outstanding residue has arrived
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_residues.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int unsigned count, int unsigned pct);
        for (int k = 0; k < count; k++)
        begin
            sender_gap(pct);
            send_exponents(pick_exponent(), pick_exponent(), 1'b0, '0);
        end
    endtask

    // Result checker: every done pulse is compared with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("residue: expected none, actual %0d", residue);
                mismatches++;
            end
            else
            begin
                oldest_residue = pending_residues.pop_front();
                if (residue !== oldest_residue)
                begin
                    $error("residue: expected %0d, actual %0d", oldest_residue, residue);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        // zero exponents and zero base
        add_row(31'd0, 31'd0, 1'b1, 30'd1);
        add_row(31'd1, 31'd0, 1'b1, 30'd0);
        add_row(EXP_MAX, 31'd0, 1'b1, 30'd0);
        add_row(31'd0, EXP_MAX, 1'b1, 30'd1);
        add_row(31'd0, 31'd1, 1'b1, 30'd1);
        // base of one
        add_row(EXP_MAX, 31'd1, 1'b1, 30'd1);
        add_row(31'd1, 31'd1, 1'b1, 30'd1);
        // small powers
        add_row(31'd1, 31'd2, 1'b1, 30'd3);
        add_row(31'd2, 31'd2, 1'b1, 30'd9);
        add_row(31'd3, 31'd3, 1'b1, 30'd343);
        // base reduced past the modulus
        add_row(31'd1, 31'd30, 1'b1, 30'd73741816);
        add_row(31'd1, 31'd31, 1'b1, 30'd147483633);
        // 2^m = 1 mod p, so the base wraps to zero
        add_row(31'd5, 31'd500000003, 1'b1, 30'd0);
        add_row(31'd0, 31'd500000003, 1'b1, 30'd1);
        add_row(31'd7, 31'd1000000006, 1'b1, 30'd0);
        // outer exponent p-1 and p
        add_row(31'd1000000006, 31'd2, 1'b1, 30'd1);
        add_row(31'd1000000007, 31'd2, 1'b1, 30'd3);
        // predicted rows
        add_row(EXP_MAX, EXP_MAX, 1'b0, '0);
        add_row(EXP_MAX, 31'd2, 1'b0, '0);
        add_row(31'd2, EXP_MAX, 1'b0, '0);
        add_row(31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0);
        add_row(31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0);
        add_row(31'h4000_0000, 31'h4000_0000, 1'b0, '0);
        add_row(31'd12345, 31'd678901, 1'b0, '0);

        // hold reset, then release it after a falling edge
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
            send_exponents(directed_rows[r].outer, directed_rows[r].inner,
                           directed_rows[r].known, directed_rows[r].residue);
        drain_results();

        random_phase(600, 7);
        drain_results();
        random_phase(600, 49);
        drain_results();
        random_phase(526, 0);

        // wait out the last transaction, then watch for stray strobes
        drain_results();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatches == 0 && pending_residues.size() == 0)
            $display("mod_prime_power_of_mersenne_top: match");
        else
            $display("mod_prime_power_of_mersenne_top: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("mod_prime_power_of_mersenne_top: mismatch");
        $finish;
    end

endmodule
